/* design/argmax_base_phred_quality_core_macros.svh */
// assertion macros for the base call core and its quality stage
// no dependencies; taken in by the files that carry assertions
`ifndef ARGMAX_BASE_PHRED_QUALITY_CORE_MACROS_SVH
`define ARGMAX_BASE_PHRED_QUALITY_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define ABPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles, off while in reset
`define ABPQ_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

/* design/abpq_pkg.sv */
// types, constants and small functions of the base call core
// no dependencies; imported by every module of the core
package abpq_pkg;

  localparam int unsigned ProbWidth    = 33;
  localparam int unsigned ProbFracBits = 32;
  localparam int unsigned ClassMax     = 5;
  localparam int unsigned ClassWidth   = 3;
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned QualWidth    = 7;
  localparam int unsigned QualCap      = 70;
  localparam int unsigned QualOffset   = 33;
  // register stages from accepted item to result strobe
  localparam int unsigned PipeDepth    = 5;

  localparam logic [ProbWidth-1:0] ProbOne = ProbWidth'(64'd1 << ProbFracBits);

  typedef enum logic [ClassWidth-1:0] {
    ClassGap = 3'd0,
    ClassA   = 3'd1,
    ClassC   = 3'd2,
    ClassG   = 3'd3,
    ClassT   = 3'd4
  } class_e;

  localparam logic [CharWidth-1:0] SymGap = 8'h2A;
  localparam logic [CharWidth-1:0] SymA   = 8'h41;
  localparam logic [CharWidth-1:0] SymC   = 8'h43;
  localparam logic [CharWidth-1:0] SymG   = 8'h47;
  localparam logic [CharWidth-1:0] SymT   = 8'h54;

  // floor(10^(-q/10) * 2^32) for q = 1..70, entry q-1
  localparam logic [ProbFracBits-1:0] QualThresh [QualCap] = '{
    32'd3411613790, 32'd2709941159, 32'd2152582777, 32'd1709857277, 32'd1358187913,
    32'd1078847007, 32'd856958638,  32'd680706442,  32'd540704347,  32'd429496729,
    32'd341161379,  32'd270994115,  32'd215258277,  32'd170985727,  32'd135818791,
    32'd107884700,  32'd85695863,   32'd68070644,   32'd54070434,   32'd42949672,
    32'd34116137,   32'd27099411,   32'd21525827,   32'd17098572,   32'd13581879,
    32'd10788470,   32'd8569586,    32'd6807064,    32'd5407043,    32'd4294967,
    32'd3411613,    32'd2709941,    32'd2152582,    32'd1709857,    32'd1358187,
    32'd1078847,    32'd856958,     32'd680706,     32'd540704,     32'd429496,
    32'd341161,     32'd270994,     32'd215258,     32'd170985,     32'd135818,
    32'd107884,     32'd85695,      32'd68070,      32'd54070,      32'd42949,
    32'd34116,      32'd27099,      32'd21525,      32'd17098,      32'd13581,
    32'd10788,      32'd8569,       32'd6807,       32'd5407,       32'd4294,
    32'd3411,       32'd2709,       32'd2152,       32'd1709,       32'd1358,
    32'd1078,       32'd856,        32'd680,        32'd540,        32'd429
  };

  typedef struct packed {
    logic [ProbWidth-1:0] prob_gap;
    logic [ProbWidth-1:0] prob_a;
    logic [ProbWidth-1:0] prob_c;
    logic [ProbWidth-1:0] prob_g;
    logic [ProbWidth-1:0] prob_t;
  } item_t;

  typedef struct packed {
    logic [ClassWidth-1:0] winning_class;
    logic [CharWidth-1:0]  base_char;
    logic [QualWidth-1:0]  quality_char;
  } result_t;

  // one contender of the compare tree
  typedef struct packed {
    logic                  en;
    logic [ClassWidth-1:0] cls;
    logic [ProbWidth-1:0]  prob;
  } cand_t;

  // winner and its error, handed from the compare tree to the quality stage
  typedef struct packed {
    logic                  valid;
    logic [ClassWidth-1:0] cls;
    logic [ProbWidth-1:0]  err;
  } best_t;

  // right side wins only when enabled and strictly larger: lower index keeps ties
  function automatic cand_t pick(cand_t left, cand_t right);
    return (right.en && (right.prob > left.prob)) ? right : left;
  endfunction

  function automatic logic [CharWidth-1:0] base_symbol(logic [ClassWidth-1:0] cls);
    logic [CharWidth-1:0] sym;
    unique case (cls)
      ClassGap: sym = SymGap;
      ClassA:   sym = SymA;
      ClassC:   sym = SymC;
      ClassG:   sym = SymG;
      ClassT:   sym = SymT;
      default:  sym = SymGap;
    endcase
    return sym;
  endfunction

endpackage

/* design/abpq_argmax.sv */
// three-stage compare tree: picks the largest class and forms its error
// depends on abpq_pkg
module abpq_argmax import abpq_pkg::*; #(
  parameter int unsigned CLASS_COUNT = 5
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output best_t best_o
);

  cand_t cand [ClassMax];

  always_comb begin
    cand[0].prob = item_i.prob_gap;
    cand[1].prob = item_i.prob_a;
    cand[2].prob = item_i.prob_c;
    cand[3].prob = item_i.prob_g;
    cand[4].prob = item_i.prob_t;
    for (int i = 0; i < ClassMax; i++) begin
      cand[i].en  = (i < CLASS_COUNT);
      cand[i].cls = ClassWidth'(i);
    end
  end

  // stage a: first-round pairs
  logic  va_q;
  cand_t a01_q, a23_q, a4_q;
  // stage b: second round
  logic  vb_q;
  cand_t b03_q, b4_q;
  // stage c: final winner and error
  logic  vc_q;
  logic  [ClassWidth-1:0] cls_q;
  logic  [ProbWidth-1:0]  err_q;

  cand_t final_d;
  logic  [ProbWidth-1:0] err_d;

  always_comb begin
    final_d = pick(b03_q, b4_q);
    err_d   = (final_d.prob >= ProbOne) ? '0 : ProbOne - final_d.prob;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a01_q <= pick(cand[0], cand[1]);
    a23_q <= pick(cand[2], cand[3]);
    a4_q  <= cand[4];
    b03_q <= pick(a01_q, a23_q);
    b4_q  <= a4_q;
    cls_q <= final_d.cls;
    err_q <= err_d;
  end

  assign best_o = '{valid: vc_q, cls: cls_q, err: err_q};

endmodule

/* design/abpq_phred.sv */
// two-stage quality unit: threshold compares, then thermometer decode
// depends on abpq_pkg and the assertion macro header
`include "argmax_base_phred_quality_core_macros.svh"

module abpq_phred import abpq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  best_t   best_i,
  output logic    valid_o,
  output result_t result_o
);

  // stage d: one compare per quality step, thermometer coded
  logic                  vd_q;
  logic [ClassWidth-1:0] cls_q;
  logic [QualCap-1:0]    therm_q;
  logic [QualCap-1:0]    therm_d;
  // stage e: result register
  logic                  ve_q;
  result_t               result_q;

  logic [QualCap:0]      hit;
  logic [QualWidth-1:0]  qual_char;

  always_comb begin
    for (int k = 0; k < QualCap; k++) begin
      therm_d[k] = (best_i.err <= {1'b0, QualThresh[k]});
    end
  end

  // thresholds fall with q, so exactly one step edge is found
  always_comb begin
    hit[0]       = ~therm_q[0];
    hit[QualCap] = therm_q[QualCap-1];
    for (int k = 1; k < QualCap; k++) begin
      hit[k] = therm_q[k-1] & ~therm_q[k];
    end
    qual_char = '0;
    for (int k = 0; k <= QualCap; k++) begin
      qual_char = qual_char | (hit[k] ? QualWidth'(k + QualOffset) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      vd_q <= best_i.valid;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    therm_q                <= therm_d;
    cls_q                  <= best_i.cls;
    result_q.winning_class <= cls_q;
    result_q.base_char     <= base_symbol(cls_q);
    result_q.quality_char  <= qual_char;
  end

  assign valid_o  = ve_q;
  assign result_o = result_q;

  `ABPQ_ASSERT_IMP(a_step_onehot, clk_i, rst_ni, vd_q, $onehot(hit), "quality step not unique")
  `ABPQ_ASSERT_IMP(a_qual_range, clk_i, rst_ni, ve_q, (result_q.quality_char >= QualWidth'(QualOffset)) && (result_q.quality_char <= QualWidth'(QualOffset + QualCap)), "quality out of range")
  `ABPQ_ASSERT_IMP(a_symbol_match, clk_i, rst_ni, ve_q, result_q.base_char == base_symbol(result_q.winning_class), "symbol does not match class")

endmodule

/* design/argmax_base_phred_quality_core.sv */
// top level of the consensus base call core with phred quality
// depends on abpq_pkg, abpq_argmax, abpq_phred and the assertion macro header
//
// usage
//   one item per position: five class probabilities on item_i, unsigned fixed
//   point where 2^32 means 1.0; an item transfers on a rising edge with start
//   high and busy low
//   busy is always low: the pipeline takes a new item in every cycle
//   each item yields one result on result_o: winning class (largest
//   probability, lowest index on ties), its symbol '*','A','C','G','T', and the
//   quality character 33..103
//   valid_o marks a result for exactly one cycle; the result transfers at the
//   edge closing that cycle, and the receiver cannot hold it off
//   the item passes through register stages a to e in order; valid_o is the
//   stage e valid bit, and result_o is the stage e result register
//   throughput: one item per cycle, since every stage is a plain register with
//   no feedback (three compare-tree stages, then threshold compare and decode)
//   reset clears every stage valid bit, so no stale results appear;
//   payload registers are not reset
//   classes at index CLASS_COUNT and above never win
`include "argmax_base_phred_quality_core_macros.svh"

module argmax_base_phred_quality_core import abpq_pkg::*; #(
  parameter int unsigned CLASS_COUNT = 5
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    valid_o,
  output result_t result_o
);

  // fully pipelined, never stalls
  assign busy = 1'b0;

  logic  accept;
  best_t best;

  assign accept = start & ~busy;

  // compare tree: stages a to c
  abpq_argmax #(
    .CLASS_COUNT(CLASS_COUNT)
  ) u_argmax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .item_i (item_i),
    .best_o (best)
  );

  // quality unit: stages d and e
  abpq_phred u_phred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .best_i  (best),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  `ABPQ_ASSERT_DLY(a_latency, clk_i, rst_ni, accept, PipeDepth, valid_o, "result missing")
  `ABPQ_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, valid_o, $past(accept, PipeDepth), "stray result")
  `ABPQ_ASSERT_IMP(a_class_range, clk_i, rst_ni, valid_o, result_o.winning_class < CLASS_COUNT, "disabled class won")

endmodule
